>>> rtl/grmd_pkg.sv
// ----------------------------------------------------------------------------
// grmd_pkg: shared constants, types and table builders for the grid ray march
// Holds the fixed-point formats, reciprocal constants, register reset values
// and the quarter-wave sine table generator used by the datapath.
// ----------------------------------------------------------------------------
package grmd_pkg;

	// Geometry and limits
	localparam int CELL_SIZE    = 50;
	localparam int GRID_CELLS   = 10;
	localparam int MAX_STEPS    = 500;
	localparam int SINE_ENTRIES = 1024;

	// Field widths
	localparam int POS_W   = 17;
	localparam int HEAD_W  = 15;
	localparam int DIST_W  = 9;
	localparam int OUTC_W  = 2;
	localparam int SDATA_W = 56;
	localparam int MDATA_W = 16;

	// Map registers: register r holds rows 2r (bits 0-9) and 2r+1 (bits 10-19)
	localparam int MAP_REGS   = 5;
	localparam int ROW_BITS   = 10;
	localparam int MAP_BITS   = 20;
	localparam int MAP_FLAT   = MAP_REGS * MAP_BITS;
	localparam int MAP_IDX_W  = $clog2(MAP_FLAT);
	localparam int CFG_ADDR_W = $clog2(MAP_REGS);

	typedef logic [MAP_BITS-1:0] map_word_t;
	typedef map_word_t map_bank_t [MAP_REGS];

	localparam map_bank_t MAP_RESET = '{
		20'd526335, 20'd525937, 20'd525825, 20'd591373, 20'd1048129
	};

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MAP_ROWS_0_1 = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAP_ROWS_8_9 = 3'd4;

	// Outcome codes
	localparam logic [OUTC_W-1:0] OUTC_WALL  = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_LEFT  = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_LIMIT = 2'd2;

	// Heading in 1/64 degree
	localparam int FULL_TURN    = 23040;
	localparam int QUARTER_TURN = 5760;
	localparam int QUAD_W       = 2;
	localparam int REM_W        = $clog2(QUARTER_TURN);

	// Table index = (r * SINE_ENTRIES + QUARTER_TURN/2) / QUARTER_TURN, done as a
	// multiply by a rounded-up reciprocal; the shift is wide enough to be exact.
	localparam int NUM_W       = $clog2((QUARTER_TURN - 1) * SINE_ENTRIES + QUARTER_TURN / 2 + 1);
	localparam int RECIP_SHIFT = NUM_W + REM_W;
	localparam int RECIP_W     = NUM_W + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(QUARTER_TURN) - 64'd1) / 64'(QUARTER_TURN));
	localparam int PROD_W      = NUM_W + RECIP_W;
	localparam int IDX_W       = $clog2(SINE_ENTRIES + 1);

	// Sine values (Q1.14) and signed steps
	localparam int SINE_W  = 15;
	localparam int DELTA_W = 16;
	localparam int FRAC    = 14;

	// Cell index from the integer part of a position, by reciprocal
	localparam int GRID_SPAN    = GRID_CELLS * CELL_SIZE;
	localparam int U_W          = $clog2(GRID_SPAN);
	localparam int CELL_LOG     = $clog2(CELL_SIZE);
	localparam int CELL_SHIFT   = U_W + CELL_LOG;
	localparam int CELL_RECIP_W = U_W + 1;
	localparam logic [CELL_RECIP_W-1:0] CELL_RECIP =
		CELL_RECIP_W'((2 ** CELL_SHIFT + CELL_SIZE - 1) / CELL_SIZE);
	localparam int CELL_PROD_W  = U_W + CELL_RECIP_W;
	localparam int CX_W         = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

	// Accumulator width (signed Q.14)
	localparam int PX_A = $clog2((2 ** 23) + MAX_STEPS * 16384) + 1;
	localparam int PX_B = U_W + FRAC + 2;
	localparam int PX_W = (PX_A > PX_B) ? PX_A : PX_B;
	localparam int UX_W = PX_W - 1 - FRAC;

	// Step counter and distance saturation
	localparam int STEP_W   = $clog2(MAX_STEPS + 1);
	localparam int DIST_MAX = 511;

	// Controller to datapath commands and status
	typedef struct packed {
		logic load;
		logic index;
		logic fetch;
		logic sign;
		logic advance;
		logic commit;
	} grmd_cmd_t;

	typedef struct packed {
		logic stop;
	} grmd_status_t;

	typedef struct packed {
		logic [QUAD_W-1:0] quad;
		logic [REM_W-1:0]  rem;
	} turn_split_t;

	// Split a heading in 0..FULL_TURN-1 into quadrant and remainder
	function automatic turn_split_t split_turn(input logic [HEAD_W-1:0] h);
		turn_split_t s;
		if (h >= HEAD_W'(3 * QUARTER_TURN)) begin
			s.quad = 2'd3;
			s.rem  = REM_W'(h - HEAD_W'(3 * QUARTER_TURN));
		end else if (h >= HEAD_W'(2 * QUARTER_TURN)) begin
			s.quad = 2'd2;
			s.rem  = REM_W'(h - HEAD_W'(2 * QUARTER_TURN));
		end else if (h >= HEAD_W'(QUARTER_TURN)) begin
			s.quad = 2'd1;
			s.rem  = REM_W'(h - HEAD_W'(QUARTER_TURN));
		end else begin
			s.quad = 2'd0;
			s.rem  = REM_W'(h);
		end
		return s;
	endfunction

	// Taylor series divisors (2n)(2n+1), n = 1..12
	localparam int TAYLOR_TERMS = 12;
	typedef logic [63:0] taylor_div_t [TAYLOR_TERMS];
	localparam taylor_div_t TAYLOR_DIV = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Entry k of the quarter-wave table: Q30 Taylor series, truncating products,
	// rounded half up to Q14 and clamped to one.
	function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_ENTRIES);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n % 2) == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		v = (sum * 64'd16384 + (64'd1 << 29)) >> 30;
		if (v > 64'd16384) begin
			v = 64'd16384;
		end
		return SINE_W'(v);
	endfunction

	typedef logic [SINE_W-1:0] sine_rom_t [SINE_ENTRIES+1];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		for (int k = 0; k <= SINE_ENTRIES; k++) begin
			rom[k] = quarter_sine(k);
		end
		return rom;
	endfunction

endpackage

>>> rtl/grid_ray_march_distance.sv
// ----------------------------------------------------------------------------
// grid_ray_march_distance: fixed-point ray march across a walled grid
// Marches a ray in unit steps from a start point along a heading and returns
// the step count and whether it hit a wall, left the grid or ran out of steps.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  -------  ---------  --------------------  ------------------------------------
//  cfg      in         cfg_valid/cfg_ready   cfg_addr = map register, cfg_data
//  s        in         s_tvalid/s_tready     start_x, start_y, heading
//  m        out        m_tvalid/m_tready     distance (tdata), outcome (tuser)
//
//  A ray passes through set-up (heading reduction, index multiply, sine table
//  read, sign) and then marches one step per cycle until it must stop.
//  The map registers reset to the built-in bordered map; no clearing pass.
//  A finished result waits in the output register; the march holds its final
//  step only while that register is still full, then the input reopens.
//  Configuration writes are taken every cycle.
//
module grid_ray_march_distance (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [grmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [grmd_pkg::MAP_BITS-1:0]       cfg_data,
	// Ray requests
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [grmd_pkg::SDATA_W-1:0]        s_tdata,  // start_x, start_y, heading, pad
	// Ray results
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [grmd_pkg::MDATA_W-1:0]        m_tdata,  // distance, pad
	output logic [grmd_pkg::OUTC_W-1:0]         m_tuser   // outcome
);

	localparam int X_LO = 0;
	localparam int Y_LO = grmd_pkg::POS_W;
	localparam int H_LO = 2 * grmd_pkg::POS_W;

	grmd_pkg::grmd_cmd_t           cmd;
	grmd_pkg::grmd_status_t        status;
	logic [grmd_pkg::DIST_W-1:0]   distance;

	// Map registers are plain flops: always ready for a write beat
	assign cfg_ready = 1'b1;

	grmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	grmd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.start_x   (s_tdata[X_LO +: grmd_pkg::POS_W]),
		.start_y   (s_tdata[Y_LO +: grmd_pkg::POS_W]),
		.heading   (s_tdata[H_LO +: grmd_pkg::HEAD_W]),
		.cmd       (cmd),
		.status    (status),
		.distance  (distance),
		.outcome   (m_tuser)
	);

	// Pad the distance out to whole bytes
	assign m_tdata = grmd_pkg::MDATA_W'(distance);

endmodule

>>> rtl/grmd_ctrl.sv
// ----------------------------------------------------------------------------
// grmd_ctrl: sequencer for the grid ray march
// Steps one ray through set-up, the march loop and result hand-over, and owns
// the input ready and output valid.
// ----------------------------------------------------------------------------
module grmd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output grmd_pkg::grmd_cmd_t    cmd,
	input  grmd_pkg::grmd_status_t status
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INDEX = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_MARCH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	// The result slot may be overwritten in the cycle its beat leaves
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_INDEX;
				end
			end
			ST_INDEX: begin
				cmd.index = 1'b1;
				state_d   = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = ST_SIGN;
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = ST_MARCH;
			end
			ST_MARCH: begin
				if (!status.stop) begin
					cmd.advance = 1'b1;
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/grmd_datapath.sv
// ----------------------------------------------------------------------------
// grmd_datapath: map registers, step look-up and position accumulators
// Works out the sine and cosine steps from the heading, then marches the
// position one step per cycle and reports when the ray must stop.
// ----------------------------------------------------------------------------
module grmd_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [grmd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [grmd_pkg::MAP_BITS-1:0]         cfg_data,
	input  logic [grmd_pkg::POS_W-1:0]            start_x,
	input  logic [grmd_pkg::POS_W-1:0]            start_y,
	input  logic [grmd_pkg::HEAD_W-1:0]           heading,
	input  grmd_pkg::grmd_cmd_t                   cmd,
	output grmd_pkg::grmd_status_t                status,
	output logic [grmd_pkg::DIST_W-1:0]           distance,
	output logic [grmd_pkg::OUTC_W-1:0]           outcome
);

	localparam grmd_pkg::sine_rom_t SINE_ROM = grmd_pkg::build_sine_rom();

	// Map registers
	grmd_pkg::map_bank_t                map_q;
	logic [grmd_pkg::MAP_FLAT-1:0]      map_flat;

	// Set-up
	logic [grmd_pkg::HEAD_W-1:0]        h_q;
	logic [grmd_pkg::HEAD_W-1:0]        h_cos;
	grmd_pkg::turn_split_t              sin_split;
	grmd_pkg::turn_split_t              cos_split;
	logic [grmd_pkg::QUAD_W-1:0]        quad_sin_q;
	logic [grmd_pkg::QUAD_W-1:0]        quad_cos_q;
	logic [grmd_pkg::PROD_W-1:0]        prod_sin_q;
	logic [grmd_pkg::PROD_W-1:0]        prod_cos_q;
	logic [grmd_pkg::IDX_W-1:0]         idx_sin;
	logic [grmd_pkg::IDX_W-1:0]         idx_cos;
	logic [grmd_pkg::IDX_W-1:0]         addr_sin;
	logic [grmd_pkg::IDX_W-1:0]         addr_cos;
	logic [grmd_pkg::SINE_W-1:0]        mag_sin_q;
	logic [grmd_pkg::SINE_W-1:0]        mag_cos_q;
	logic                               neg_sin_q;
	logic                               neg_cos_q;
	logic signed [grmd_pkg::DELTA_W-1:0] dx_q;
	logic signed [grmd_pkg::DELTA_W-1:0] dy_q;

	// March
	logic signed [grmd_pkg::PX_W-1:0]   px_q;
	logic signed [grmd_pkg::PX_W-1:0]   py_q;
	logic [grmd_pkg::STEP_W-1:0]        steps_q;
	logic [grmd_pkg::UX_W-1:0]          ux;
	logic [grmd_pkg::UX_W-1:0]          uy;
	logic                               left_grid;
	logic [grmd_pkg::CELL_PROD_W-1:0]   cell_prod_x;
	logic [grmd_pkg::CELL_PROD_W-1:0]   cell_prod_y;
	logic [grmd_pkg::CX_W-1:0]          cx;
	logic [grmd_pkg::CX_W-1:0]          cy;
	logic                               in_map;
	logic [grmd_pkg::MAP_IDX_W-1:0]     map_idx;
	logic                               wall;
	logic                               limit;
	logic [grmd_pkg::STEP_W+grmd_pkg::DIST_W-1:0] steps_wide;
	logic [grmd_pkg::DIST_W-1:0]        dist_sat;
	logic [grmd_pkg::OUTC_W-1:0]        outc_d;
	logic [grmd_pkg::DIST_W-1:0]        dist_q;
	logic [grmd_pkg::OUTC_W-1:0]        outc_q;

	// Map registers reset to the built-in bordered map; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= grmd_pkg::MAP_RESET;
		end else if (cfg_write && (cfg_addr <= grmd_pkg::REG_MAP_ROWS_8_9)) begin
			map_q[cfg_addr] <= cfg_data;
		end
	end

	// Row r of the map sits at bits r*ROW_BITS up
	always_comb begin
		for (int r = 0; r < grmd_pkg::MAP_REGS; r++) begin
			map_flat[r*grmd_pkg::MAP_BITS +: grmd_pkg::MAP_BITS] = map_q[r];
		end
	end

	// Cosine is the sine a quarter turn on
	always_comb begin
		if (h_q >= grmd_pkg::HEAD_W'(grmd_pkg::FULL_TURN - grmd_pkg::QUARTER_TURN)) begin
			h_cos = h_q - grmd_pkg::HEAD_W'(grmd_pkg::FULL_TURN - grmd_pkg::QUARTER_TURN);
		end else begin
			h_cos = h_q + grmd_pkg::HEAD_W'(grmd_pkg::QUARTER_TURN);
		end
		sin_split = grmd_pkg::split_turn(h_q);
		cos_split = grmd_pkg::split_turn(h_cos);
	end

	// Table index, clamped, mirrored in odd quadrants
	always_comb begin
		idx_sin = grmd_pkg::IDX_W'(prod_sin_q >> grmd_pkg::RECIP_SHIFT);
		idx_cos = grmd_pkg::IDX_W'(prod_cos_q >> grmd_pkg::RECIP_SHIFT);
		if (idx_sin > grmd_pkg::IDX_W'(grmd_pkg::SINE_ENTRIES)) begin
			idx_sin = grmd_pkg::IDX_W'(grmd_pkg::SINE_ENTRIES);
		end
		if (idx_cos > grmd_pkg::IDX_W'(grmd_pkg::SINE_ENTRIES)) begin
			idx_cos = grmd_pkg::IDX_W'(grmd_pkg::SINE_ENTRIES);
		end
		addr_sin = quad_sin_q[0] ? grmd_pkg::IDX_W'(grmd_pkg::SINE_ENTRIES) - idx_sin : idx_sin;
		addr_cos = quad_cos_q[0] ? grmd_pkg::IDX_W'(grmd_pkg::SINE_ENTRIES) - idx_cos : idx_cos;
	end

	// Position check and cell look-up
	always_comb begin
		ux          = px_q[grmd_pkg::PX_W-2:grmd_pkg::FRAC];
		uy          = py_q[grmd_pkg::PX_W-2:grmd_pkg::FRAC];
		left_grid   = px_q[grmd_pkg::PX_W-1] || py_q[grmd_pkg::PX_W-1] ||
		              (ux >= grmd_pkg::UX_W'(grmd_pkg::GRID_SPAN)) ||
		              (uy >= grmd_pkg::UX_W'(grmd_pkg::GRID_SPAN));
		cell_prod_x = grmd_pkg::CELL_PROD_W'(ux[grmd_pkg::U_W-1:0]) *
		              grmd_pkg::CELL_PROD_W'(grmd_pkg::CELL_RECIP);
		cell_prod_y = grmd_pkg::CELL_PROD_W'(uy[grmd_pkg::U_W-1:0]) *
		              grmd_pkg::CELL_PROD_W'(grmd_pkg::CELL_RECIP);
		cx          = grmd_pkg::CX_W'(cell_prod_x >> grmd_pkg::CELL_SHIFT);
		cy          = grmd_pkg::CX_W'(cell_prod_y >> grmd_pkg::CELL_SHIFT);
		// Cells past the stored map read as open floor
		in_map      = (int'(cx) < grmd_pkg::ROW_BITS) && (int'(cy) < grmd_pkg::ROW_BITS);
		map_idx     = grmd_pkg::MAP_IDX_W'(int'(cx) * grmd_pkg::ROW_BITS + int'(cy));
		wall        = in_map ? map_flat[map_idx] : 1'b0;
		limit       = (steps_q == grmd_pkg::STEP_W'(grmd_pkg::MAX_STEPS));
	end

	always_comb begin
		status.stop = limit || left_grid || wall;
		priority if (limit) begin
			outc_d = grmd_pkg::OUTC_LIMIT;
		end else if (left_grid) begin
			outc_d = grmd_pkg::OUTC_LEFT;
		end else begin
			outc_d = grmd_pkg::OUTC_WALL;
		end
		steps_wide = (grmd_pkg::STEP_W + grmd_pkg::DIST_W)'(steps_q);
		if (steps_wide > (grmd_pkg::STEP_W + grmd_pkg::DIST_W)'(grmd_pkg::DIST_MAX)) begin
			dist_sat = grmd_pkg::DIST_W'(grmd_pkg::DIST_MAX);
		end else begin
			dist_sat = grmd_pkg::DIST_W'(steps_wide);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q     <= (heading >= grmd_pkg::HEAD_W'(grmd_pkg::FULL_TURN)) ?
			           heading - grmd_pkg::HEAD_W'(grmd_pkg::FULL_TURN) : heading;
			px_q    <= grmd_pkg::PX_W'({start_x, 6'b0});
			py_q    <= grmd_pkg::PX_W'({start_y, 6'b0});
			steps_q <= '0;
		end
		if (cmd.index) begin
			quad_sin_q <= sin_split.quad;
			quad_cos_q <= cos_split.quad;
			prod_sin_q <= (grmd_pkg::PROD_W'(sin_split.rem) *
			               grmd_pkg::PROD_W'(grmd_pkg::SINE_ENTRIES) +
			               grmd_pkg::PROD_W'(grmd_pkg::QUARTER_TURN / 2)) *
			              grmd_pkg::PROD_W'(grmd_pkg::RECIP);
			prod_cos_q <= (grmd_pkg::PROD_W'(cos_split.rem) *
			               grmd_pkg::PROD_W'(grmd_pkg::SINE_ENTRIES) +
			               grmd_pkg::PROD_W'(grmd_pkg::QUARTER_TURN / 2)) *
			              grmd_pkg::PROD_W'(grmd_pkg::RECIP);
		end
		if (cmd.fetch) begin
			mag_sin_q <= SINE_ROM[addr_sin];
			mag_cos_q <= SINE_ROM[addr_cos];
			neg_sin_q <= quad_sin_q[1];
			neg_cos_q <= quad_cos_q[1];
		end
		if (cmd.sign) begin
			dx_q <= neg_sin_q ? -$signed(grmd_pkg::DELTA_W'(mag_sin_q)) :
			                     $signed(grmd_pkg::DELTA_W'(mag_sin_q));
			dy_q <= neg_cos_q ? -$signed(grmd_pkg::DELTA_W'(mag_cos_q)) :
			                     $signed(grmd_pkg::DELTA_W'(mag_cos_q));
		end
		if (cmd.advance) begin
			px_q    <= px_q + grmd_pkg::PX_W'(dx_q);
			py_q    <= py_q + grmd_pkg::PX_W'(dy_q);
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.commit) begin
			dist_q <= dist_sat;
			outc_q <= outc_d;
		end
	end

	assign distance = dist_q;
	assign outcome  = outc_q;

endmodule

>>> tb/sv/grid_ray_march_checker.sv
// ----------------------------------------------------------------------------
// grid_ray_march_checker: result predictor and scoreboard for the ray march
// Watches the configuration, request and result channels, keeps its own copy
// of the wall map, marches every accepted ray in fixed point and compares each
// result beat with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module grid_ray_march_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [grmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [grmd_pkg::MAP_BITS-1:0]       cfg_data,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [grmd_pkg::SDATA_W-1:0]        s_tdata,   // start_x, start_y, heading, pad
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [grmd_pkg::MDATA_W-1:0]        m_tdata,   // distance, pad
	input  logic [grmd_pkg::OUTC_W-1:0]         m_tuser,   // outcome
	output int                                  failures,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import grmd_pkg::*;

	localparam int          CELL_UNITS    = 50;
	localparam int          GRID_N        = 10;
	localparam int          STEP_LIMIT    = 500;
	localparam int          WAVE_ENTRIES  = 1024;
	localparam int          TURN_UNITS    = 23040;
	localparam int          QUARTER_UNITS = 5760;
	localparam int          CELL_SPAN     = CELL_UNITS * 16384;
	localparam int          DIST_CAP      = 511;
	localparam int          ROW_LEN       = 10;
	localparam logic [63:0] QUARTER_ARC   = 64'd1686629713;  // pi/2 in Q30

	localparam map_bank_t BORDERED_MAP = '{
		20'd526335, 20'd525937, 20'd525825, 20'd591373, 20'd1048129
	};

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [OUTC_W-1:0] outcome;
	} ray_result_t;

	map_bank_t         walls;
	logic [14:0]       wave_table [WAVE_ENTRIES+1];
	ray_result_t       ray_results [$];

	// Quarter-wave entry: Q30 Taylor series with truncating products,
	// rounded half up to Q14 and clamped to one
	function automatic logic [14:0] wave_point(input int unsigned k);
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] rounded;
		ang    = (QUARTER_ARC * 64'(k)) / 64'(WAVE_ENTRIES);
		ang_sq = (ang * ang) >> 30;
		term   = ang;
		acc    = ang;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = (acc >= term) ? acc - term : 64'd0;
			end else begin
				acc = acc + term;
			end
		end
		rounded = (acc * 64'd16384 + (64'd1 << 29)) >> 30;
		if (rounded > 64'd16384) begin
			rounded = 64'd16384;
		end
		return rounded[14:0];
	endfunction

	// Signed Q1.14 sine of a heading already reduced to one turn
	function automatic int heading_sine(input int unsigned h);
		int unsigned quad;
		int unsigned rem;
		int unsigned idx;
		int          mag;
		quad = h / QUARTER_UNITS;
		rem  = h % QUARTER_UNITS;
		idx  = (rem * WAVE_ENTRIES + QUARTER_UNITS / 2) / QUARTER_UNITS;
		if (idx > WAVE_ENTRIES) begin
			idx = WAVE_ENTRIES;
		end
		mag = (quad % 2 == 1) ? int'(wave_table[WAVE_ENTRIES - idx]) : int'(wave_table[idx]);
		return (quad >= 2) ? -mag : mag;
	endfunction

	// The x cell picks the map row, the y cell the bit within it
	function automatic logic wall_bit(input int row, input int col);
		if (row >= ROW_LEN || col >= ROW_LEN) begin
			return 1'b0;
		end
		return walls[row / 2][(row % 2) * ROW_LEN + col];
	endfunction

	function automatic ray_result_t march_ray(
		input logic [POS_W-1:0]  sx,
		input logic [POS_W-1:0]  sy,
		input logic [HEAD_W-1:0] hdg
	);
		int unsigned h;
		int          px;
		int          py;
		int          dx;
		int          dy;
		int          steps;
		logic        done;
		ray_result_t res;
		h           = int'(hdg) % TURN_UNITS;
		dx          = heading_sine(h);
		dy          = heading_sine((h + QUARTER_UNITS) % TURN_UNITS);
		px          = int'(sx) << 6;
		py          = int'(sy) << 6;
		steps       = 0;
		done        = 1'b0;
		res.outcome = OUTC_LIMIT;
		while (!done && steps < STEP_LIMIT) begin
			if (px < 0 || py < 0) begin
				res.outcome = OUTC_LEFT;
				done        = 1'b1;
			end else if (px / CELL_SPAN >= GRID_N || py / CELL_SPAN >= GRID_N) begin
				res.outcome = OUTC_LEFT;
				done        = 1'b1;
			end else if (wall_bit(px / CELL_SPAN, py / CELL_SPAN)) begin
				res.outcome = OUTC_WALL;
				done        = 1'b1;
			end else begin
				px    = px + dx;
				py    = py + dy;
				steps = steps + 1;
			end
		end
		res.distance = DIST_W'((steps > DIST_CAP) ? DIST_CAP : steps);
		return res;
	endfunction

	initial begin
		for (int k = 0; k <= WAVE_ENTRIES; k++) begin
			wave_table[k] = wave_point(k);
		end
	end

	// Retire results first so a beat can never meet its own prediction
	always @(posedge clk or negedge arst_n) begin
		ray_result_t got;
		ray_result_t want;
		if (!arst_n) begin
			walls = BORDERED_MAP;
			ray_results.delete();
			failures <= 0;
			pending  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.distance = m_tdata[DIST_W-1:0];
				got.outcome  = m_tuser;
				if (ray_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected: distance %0d outcome %0d",
						$time, got.distance, got.outcome);
					failures <= failures + 1;
				end else begin
					want = ray_results.pop_front();
					if (got.distance !== want.distance || got.outcome !== want.outcome) begin
						$display("%0t ns: expected distance %0d outcome %0d, got distance %0d outcome %0d",
							$time, want.distance, want.outcome, got.distance, got.outcome);
						failures <= failures + 1;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				ray_results.push_back(march_ray(s_tdata[POS_W-1:0],
					s_tdata[2*POS_W-1:POS_W], s_tdata[2*POS_W+HEAD_W-1:2*POS_W]));
			end
			// Unknown register indexes fall through untouched
			if (cfg_valid && cfg_ready && int'(cfg_addr) < MAP_REGS) begin
				walls[cfg_addr] = cfg_data;
			end
			pending <= ray_results.size();
		end
	end

endmodule

>>> tb/sv/tb_grid_ray_march_distance.sv
// ----------------------------------------------------------------------------
// tb_grid_ray_march_distance: regression for the grid ray march
// Drives directed rays over the bordered, empty and solid maps, then random
// rays over random maps under changing back-pressure; the checker beside the
// block predicts every result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_grid_ray_march_distance;
	timeunit 1ns;
	timeprecision 1ps;

	import grmd_pkg::*;

	// Worst correct run is roughly 920 rays marching to the step limit, plus stalls;
	// allow several times that before calling it hung.
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int RAYS_PER_SEG  = 150;
	localparam int SEGMENTS      = 6;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = MAX_STEPS + 16;
	// Q9.8 coordinates
	localparam int UNIT          = 256;
	localparam int POS_TOP       = 127999;
	localparam int POS_FIELD_TOP = (1 << POS_W) - 1;
	// Headings in 1/64 degree
	localparam int DEG_45        = 2880;
	localparam int DEG_90        = 5760;
	localparam int DEG_180       = 11520;
	localparam int DEG_270       = 17280;
	localparam int HEAD_TOP      = 23039;
	localparam int HEAD_FIELD_TOP = (1 << HEAD_W) - 1;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [MAP_BITS-1:0]    cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [SDATA_W-1:0]     s_tdata;   // start_x, start_y, heading, pad
	logic                   m_tvalid;
	logic                   m_tready;
	logic [MDATA_W-1:0]     m_tdata;   // distance, pad
	logic [OUTC_W-1:0]      m_tuser;   // outcome

	int failures;
	int pending;
	int cycle_count = 0;

	// Back-pressure knobs, written only by the stimulus process
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	// Owned by the receiver process
	int hold_served;
	int hold_left;

	grid_ray_march_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	grid_ray_march_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.failures  (failures),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Guard against a hung block: give up after the cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("grid_ray_march_distance regression: fail");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off when the stimulus asks
	// for one. Count the hold-off here so the sender keeps offering rays
	// and the block backs up into its input.
	initial begin
		m_tready    = 1'b0;
		hold_served = 0;
		hold_left   = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready  <= 1'b0;
				hold_left = hold_left - 1;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_served + 1;
				hold_left   = HOLD_CYCLES - 1;
				m_tready    <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offer one ray, idling first at the current rate; return at the edge
	// where the beat is taken, leaving tvalid up for the next caller
	task automatic send_ray(
		input int sx,
		input int sy,
		input int hdg
	);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= SDATA_W'({HEAD_W'(hdg), POS_W'(sy), POS_W'(sx)});
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// Drop the request line and hold until every predicted result is back.
	// Let the checker count the final ray before polling.
	task automatic drain_rays();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	// Write all five map registers, then one stray write to an unused index
	task automatic load_map(input map_bank_t bank);
		for (int r = 0; r < MAP_REGS; r++) begin
			cfg_valid <= 1'b1;
			cfg_addr  <= REG_MAP_ROWS_0_1 + CFG_ADDR_W'(r);
			cfg_data  <= bank[r];
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
		end
		cfg_valid <= 1'b1;
		cfg_addr  <= REG_MAP_ROWS_8_9 + CFG_ADDR_W'($urandom_range(3, 1));
		cfg_data  <= MAP_BITS'($urandom);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		map_bank_t         bank;
		logic [MAP_BITS-1:0] w;
		int                layers;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		// Sender idles lightly and the receiver heavily to begin with
		send_idle_pct = 20;
		recv_idle_pct = 61;
		hold_requests = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bordered map from reset: heading wrap, field extremes, origin off grid
		send_ray(250 * UNIT, 250 * UNIT, 0);
		send_ray(250 * UNIT, 250 * UNIT, HEAD_TOP);
		send_ray(250 * UNIT, 250 * UNIT, HEAD_FIELD_TOP);
		send_ray(250 * UNIT, 250 * UNIT, HEAD_TOP + 1);
		send_ray(0, 0, DEG_45);
		send_ray(POS_TOP, POS_TOP, DEG_180);
		send_ray(POS_FIELD_TOP, 100 * UNIT, 0);
		send_ray(100 * UNIT, POS_FIELD_TOP, DEG_90);
		drain_rays();

		// Empty map: the step limit on the diagonal and straight runs, and
		// leaving the grid on each side
		bank = '{default: '0};
		load_map(bank);
		send_ray(0, 0, DEG_45);
		send_ray(10 * UNIT, 0, 0);
		send_ray(250 * UNIT, 250 * UNIT, DEG_90);
		send_ray(250 * UNIT, 1 * UNIT, DEG_180);
		send_ray(1 * UNIT, 250 * UNIT, DEG_270);
		send_ray(0, 0, DEG_270);
		send_ray(POS_TOP, POS_TOP, DEG_45);
		drain_rays();

		// Solid map: a wall under every origin inside the grid
		bank = '{default: '1};
		load_map(bank);
		send_ray(250 * UNIT, 250 * UNIT, 1234);
		send_ray(POS_FIELD_TOP, 0, 0);
		send_ray(0, POS_TOP, HEAD_FIELD_TOP);
		drain_rays();

		// Random rays over random maps; thin the walls by ANDing words so some
		// maps leave room for long marches and the step limit
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			layers = 1 + seg % 4;
			for (int r = 0; r < MAP_REGS; r++) begin
				w = MAP_BITS'($urandom);
				repeat (layers - 1) w = w & MAP_BITS'($urandom);
				bank[r] = w;
			end
			load_map(bank);
			// Stall the result side for a long stretch while rays keep coming
			if (seg == 4) begin
				hold_requests = hold_requests + 1;
			end
			repeat (RAYS_PER_SEG) begin
				send_ray(
					($urandom_range(9) == 0) ? $urandom_range(POS_FIELD_TOP)
						: $urandom_range(POS_TOP),
					($urandom_range(9) == 0) ? $urandom_range(POS_FIELD_TOP)
						: $urandom_range(POS_TOP),
					($urandom_range(6) == 0) ? $urandom_range(HEAD_FIELD_TOP)
						: $urandom_range(HEAD_TOP));
			end
			drain_rays();
		end

		// Let any stray beat show itself before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("grid_ray_march_distance regression: pass");
		end else begin
			$display("grid_ray_march_distance regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/grmd_pkg.sv
rtl/grmd_ctrl.sv
rtl/grmd_datapath.sv
rtl/grid_ray_march_distance.sv
tb/sv/grid_ray_march_checker.sv
tb/sv/tb_grid_ray_march_distance.sv
